// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the receive window core. They sample on
// aclk and stay quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define RRW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that an expression never holds outside reset.
`define RRW_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/rrw_pkg.sv =====
// ----------------------------------------------------------------------------
// rrw_pkg
// Shared widths, codes and defaults of the receive window core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrw_pkg;

    // Field widths fixed by the interface
    localparam int SEQ_IN_W    = 16;
    localparam int TAG_IN_W    = 8;
    localparam int WIN_CFG_W   = 6;
    localparam int LIMIT_W     = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // Parameter defaults
    localparam int WINDOW_SLOTS_DEF = 64;
    localparam int SEQ_SPACE_DEF    = 65536;
    localparam int TAG_BITS_DEF     = 8;

    // Register reset values
    localparam logic [WIN_CFG_W-1:0] WINDOW_SIZE_RST = 6'd32;
    localparam logic [LIMIT_W-1:0]   ACK_LIMIT_RST   = 8'd8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_LIMIT   = 4'd1;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_DELIVER = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_HELD    = 2'd2
    } action_t;

endpackage

// ===== rtl/core/rrw_slot_store.sv =====
// ----------------------------------------------------------------------------
// rrw_slot_store
// Out-of-order slot store: one valid flop per slot and a tag memory with a
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrw_slot_store #(
    parameter int WINDOW_SLOTS = rrw_pkg::WINDOW_SLOTS_DEF,
    parameter int TAG_BITS     = rrw_pkg::TAG_BITS_DEF,
    localparam int SLOT_W      = $clog2(WINDOW_SLOTS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    set_en,
    input  logic [SLOT_W-1:0]       set_idx,
    input  logic [TAG_BITS-1:0]     set_tag,
    input  logic                    clr_en,
    input  logic [SLOT_W-1:0]       clr_idx,
    input  logic [SLOT_W-1:0]       rd_idx,
    output logic [TAG_BITS-1:0]     rd_tag,
    output logic [WINDOW_SLOTS-1:0] valid_vec
);

    logic [WINDOW_SLOTS-1:0] valid_reg;
    logic [TAG_BITS-1:0]     tag_mem [WINDOW_SLOTS];
    logic [TAG_BITS-1:0]     rd_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (set_en) begin
                valid_reg[set_idx] <= 1'b1;
            end
            if (clr_en) begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    // Tag memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (set_en) begin
            tag_mem[set_idx] <= set_tag;
        end
        rd_tag_reg <= tag_mem[rd_idx];
    end

    assign rd_tag    = rd_tag_reg;
    assign valid_vec = valid_reg;

endmodule

// ===== rtl/core/reorder_receive_window_core.sv =====
// ----------------------------------------------------------------------------
// reorder_receive_window_core
// A control packet shows its result in the cycle after the input transfer.
// A data packet runs REDUCE, offset, optional wrap fix and classify to an
// out-of-window result; a held packet then runs the slot adds, the slot
// subtracts and HOLD; an in-order delivery scans the held slots, and each
// drained result passes FETCH and LOAD after the previous result transfer.
// Throughput: one item at a time; the next input transfer is taken the cycle
// after the last result transfer. Rate is set by the shared add/sub unit.
// Reset (aresetn low, synchronous): window empty, counters and flags clear,
// registers back to window_size 32 and ack_pending_limit 8. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module reorder_receive_window_core #(
    parameter int WINDOW_SLOTS = rrw_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_SPACE    = rrw_pkg::SEQ_SPACE_DEF,
    parameter int TAG_BITS     = rrw_pkg::TAG_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input packet channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rrw_pkg::SEQ_IN_W-1:0]     s_seq_number,
    input  logic [rrw_pkg::TAG_IN_W-1:0]     s_buffer_tag,
    input  logic                             s_is_control,
    input  logic                             s_is_datagram,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_action,
    output logic [rrw_pkg::TAG_IN_W-1:0]     m_out_tag,
    output logic [rrw_pkg::SEQ_IN_W-1:0]     m_ack_seq,
    output logic                             m_ack_needed,
    output logic                             m_explicit_ack,
    output logic                             m_last,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rrw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------------
    // Derived constants
    // ------------------------------------------------------------------------
    localparam int SEQ_BITS  = $clog2(SEQ_SPACE);
    localparam int SLOT_W    = $clog2(WINDOW_SLOTS);
    // Shared unit width: holds any sequence number and SEQ_SPACE itself
    localparam int ALU_W     = rrw_pkg::SEQ_IN_W + 1;
    // Highest shift k with SEQ_SPACE << k still able to fit a raw sequence
    localparam int RED_MAX   = $clog2((2 ** rrw_pkg::SEQ_IN_W) / SEQ_SPACE + 1) - 1;
    localparam int RED_W     = (RED_MAX > 0) ? $clog2(RED_MAX + 1) : 1;
    // Slot correction when the sequence number wrapped below next_expected
    localparam int SPACE_MOD = SEQ_SPACE % WINDOW_SLOTS;
    localparam int WRAP_ADJ  = (WINDOW_SLOTS - SPACE_MOD) % WINDOW_SLOTS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_OFFS,
        ST_ADJ,
        ST_CLASS,
        ST_SL_ADD1,
        ST_SL_ADD2,
        ST_SL_SUB1,
        ST_SL_SUB2,
        ST_HOLD,
        ST_SCAN,
        ST_EMIT,
        ST_FETCH,
        ST_LOAD
    } state_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                          state_reg;

    // Configuration
    logic [rrw_pkg::WIN_CFG_W-1:0]   win_size_reg;
    logic [rrw_pkg::LIMIT_W-1:0]     ack_limit_reg;

    // Window state
    logic [SEQ_BITS-1:0]             ne_reg;        // next expected sequence
    logic [SLOT_W-1:0]               ne_slot_reg;   // next expected mod slots
    logic [SEQ_BITS-1:0]             lio_reg;       // last in-order sequence
    logic [rrw_pkg::LIMIT_W-1:0]     pend_reg;
    logic                            owed_reg;

    // Per-item working registers (payload, no reset)
    logic [ALU_W-1:0]                acc_reg;
    logic [RED_W-1:0]                k_reg;
    logic                            wrap_reg;
    logic [TAG_BITS-1:0]             tag_reg;
    logic                            dgram_reg;

    // Drain scan and emission pointers
    logic [SEQ_BITS-1:0]             scan_ne_reg;
    logic [SLOT_W-1:0]               scan_slot_reg;
    logic [SEQ_BITS-1:0]             scan_last_reg;
    logic [SEQ_BITS-1:0]             em_ne_reg;
    logic [SLOT_W-1:0]               em_slot_reg;
    logic [SLOT_W-1:0]               cnt_reg;
    logic [SLOT_W-1:0]               rem_reg;

    // Result register
    rrw_pkg::action_t                act_reg;
    logic [rrw_pkg::TAG_IN_W-1:0]    out_tag_reg;
    logic                            expl_reg;
    logic                            last_reg;

    // ------------------------------------------------------------------------
    // Window span and pending-ack update
    // ------------------------------------------------------------------------
    logic [rrw_pkg::WIN_CFG_W-1:0]   span;
    logic [rrw_pkg::LIMIT_W-1:0]     pend_sat;
    logic                            pend_over;

    // Clamp the span so held slots never alias
    assign span = (win_size_reg > rrw_pkg::WIN_CFG_W'(WINDOW_SLOTS - 1)) ?
                  rrw_pkg::WIN_CFG_W'(WINDOW_SLOTS - 1) : win_size_reg;

    assign pend_sat  = (pend_reg == '1) ? pend_reg : pend_reg + 8'd1;
    assign pend_over = (pend_sat > ack_limit_reg);

    // ------------------------------------------------------------------------
    // Shared add/sub unit
    // ------------------------------------------------------------------------
    logic [ALU_W-1:0]                alu_a;
    logic [ALU_W-1:0]                alu_b;
    logic                            alu_sub;
    logic [ALU_W-1:0]                alu_b_eff;
    logic [ALU_W:0]                  alu_sum;
    logic [ALU_W-1:0]                alu_res;
    logic                            alu_borrow;

    always_comb begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_REDUCE: begin
                alu_b   = ALU_W'(SEQ_SPACE) << k_reg;
                alu_sub = 1'b1;
            end
            ST_OFFS: begin
                alu_b   = ALU_W'(ne_reg);
                alu_sub = 1'b1;
            end
            ST_ADJ: begin
                alu_b   = ALU_W'(SEQ_SPACE);
            end
            ST_CLASS: begin
                // span - offset: a borrow means the packet lies outside
                alu_a   = ALU_W'(span);
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            ST_SL_ADD1: begin
                alu_b   = ALU_W'(ne_slot_reg);
            end
            ST_SL_ADD2: begin
                alu_b   = wrap_reg ? ALU_W'(WRAP_ADJ) : '0;
            end
            ST_SL_SUB1, ST_SL_SUB2: begin
                alu_b   = ALU_W'(WINDOW_SLOTS);
                alu_sub = 1'b1;
            end
            default: begin
                alu_b   = '0;
            end
        endcase
    end

    assign alu_b_eff  = alu_sub ? ~alu_b : alu_b;
    assign alu_sum    = {1'b0, alu_a} + {1'b0, alu_b_eff} + (ALU_W + 1)'(alu_sub);
    assign alu_res    = alu_sum[ALU_W-1:0];
    assign alu_borrow = alu_sub & ~alu_sum[ALU_W];

    // ------------------------------------------------------------------------
    // Sequence step: advance a (sequence, slot) pair by one, wrap-aware
    // ------------------------------------------------------------------------
    logic [SEQ_BITS-1:0]             step_ne;
    logic [SLOT_W-1:0]               step_slot;
    logic                            step_wrap;
    logic [SEQ_BITS-1:0]             step_ne_nx;
    logic [SLOT_W-1:0]               step_slot_nx;

    always_comb begin
        case (state_reg)
            ST_SCAN: begin
                step_ne   = scan_ne_reg;
                step_slot = scan_slot_reg;
            end
            ST_LOAD: begin
                step_ne   = em_ne_reg;
                step_slot = em_slot_reg;
            end
            default: begin
                step_ne   = ne_reg;
                step_slot = ne_slot_reg;
            end
        endcase
    end

    assign step_wrap    = (step_ne == SEQ_BITS'(SEQ_SPACE - 1));
    assign step_ne_nx   = step_wrap ? '0 : step_ne + SEQ_BITS'(1);
    // The slot restarts at zero where the sequence space wraps
    assign step_slot_nx = (step_wrap || step_slot == SLOT_W'(WINDOW_SLOTS - 1)) ?
                          '0 : step_slot + SLOT_W'(1);

    // ------------------------------------------------------------------------
    // Slot store
    // ------------------------------------------------------------------------
    logic                            set_en;
    logic                            clr_en;
    logic [SLOT_W-1:0]               hold_slot;
    logic [TAG_BITS-1:0]             rd_tag;
    logic [WINDOW_SLOTS-1:0]         valid_vec;
    logic                            hold_dup;
    logic                            scan_hit;

    assign hold_slot = acc_reg[SLOT_W-1:0];
    assign hold_dup  = valid_vec[hold_slot];
    assign scan_hit  = valid_vec[scan_slot_reg] &&
                       (cnt_reg < SLOT_W'(WINDOW_SLOTS - 1));
    assign set_en    = (state_reg == ST_HOLD) && !hold_dup;
    assign clr_en    = (state_reg == ST_FETCH);

    rrw_slot_store #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .TAG_BITS     (TAG_BITS)
    ) u_slot_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .set_en    (set_en),
        .set_idx   (hold_slot),
        .set_tag   (tag_reg),
        .clr_en    (clr_en),
        .clr_idx   (em_slot_reg),
        .rd_idx    (em_slot_reg),
        .rd_tag    (rd_tag),
        .valid_vec (valid_vec)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            win_size_reg  <= rrw_pkg::WINDOW_SIZE_RST;
            ack_limit_reg <= rrw_pkg::ACK_LIMIT_RST;
            ne_reg        <= '0;
            ne_slot_reg   <= '0;
            lio_reg       <= '0;
            pend_reg      <= '0;
            owed_reg      <= 1'b0;
            expl_reg      <= 1'b0;
            last_reg      <= 1'b0;
            rem_reg       <= '0;
        end else begin
            // Configuration transfers land only while the block is idle
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rrw_pkg::CFG_WINDOW_SIZE) begin
                    win_size_reg <= cfg_data[rrw_pkg::WIN_CFG_W-1:0];
                end else if (cfg_index == rrw_pkg::CFG_ACK_LIMIT) begin
                    ack_limit_reg <= cfg_data[rrw_pkg::LIMIT_W-1:0];
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        tag_reg     <= TAG_BITS'(s_buffer_tag);
                        dgram_reg   <= s_is_datagram;
                        acc_reg     <= ALU_W'(s_seq_number);
                        k_reg       <= RED_W'(RED_MAX);
                        expl_reg    <= 1'b0;
                        rem_reg     <= '0;
                        // Control packets bypass windowing: release at once
                        act_reg     <= rrw_pkg::ACT_RELEASE;
                        out_tag_reg <= rrw_pkg::TAG_IN_W'(TAG_BITS'(s_buffer_tag));
                        last_reg    <= 1'b1;
                        state_reg   <= s_is_control ? ST_EMIT : ST_REDUCE;
                    end
                end

                ST_REDUCE: begin
                    // Restoring reduction of the sequence modulo SEQ_SPACE
                    if (!alu_borrow) begin
                        acc_reg <= alu_res;
                    end
                    if (k_reg == '0) begin
                        state_reg <= ST_OFFS;
                    end else begin
                        k_reg <= k_reg - RED_W'(1);
                    end
                end

                ST_OFFS: begin
                    acc_reg  <= alu_res;
                    wrap_reg <= alu_borrow;
                    if (dgram_reg) begin
                        // Every windowed datagram packet leaves an ack owed
                        owed_reg <= 1'b1;
                        if (pend_over) begin
                            expl_reg <= 1'b1;
                            pend_reg <= '0;
                        end else begin
                            pend_reg <= pend_sat;
                        end
                    end
                    state_reg <= alu_borrow ? ST_ADJ : ST_CLASS;
                end

                ST_ADJ: begin
                    acc_reg   <= alu_res;
                    state_reg <= ST_CLASS;
                end

                ST_CLASS: begin
                    if (acc_reg == '0) begin
                        // Expected packet: deliver it, then scan held slots
                        act_reg       <= rrw_pkg::ACT_DELIVER;
                        scan_last_reg <= ne_reg;
                        scan_ne_reg   <= step_ne_nx;
                        scan_slot_reg <= step_slot_nx;
                        em_ne_reg     <= step_ne_nx;
                        em_slot_reg   <= step_slot_nx;
                        cnt_reg       <= '0;
                        state_reg     <= ST_SCAN;
                    end else if (alu_borrow) begin
                        // Outside the window: release the buffer
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_SL_ADD1;
                    end
                end

                ST_SL_ADD1, ST_SL_ADD2: begin
                    acc_reg   <= alu_res;
                    state_reg <= (state_reg == ST_SL_ADD1) ? ST_SL_ADD2 : ST_SL_SUB1;
                end

                ST_SL_SUB1, ST_SL_SUB2: begin
                    if (!alu_borrow) begin
                        acc_reg <= alu_res;
                    end
                    state_reg <= (state_reg == ST_SL_SUB1) ? ST_SL_SUB2 : ST_HOLD;
                end

                ST_HOLD: begin
                    // Drop a duplicate of a held packet, otherwise hold it
                    act_reg   <= hold_dup ? rrw_pkg::ACT_RELEASE : rrw_pkg::ACT_HELD;
                    state_reg <= ST_EMIT;
                end

                ST_SCAN: begin
                    if (scan_hit) begin
                        cnt_reg       <= cnt_reg + SLOT_W'(1);
                        scan_last_reg <= scan_ne_reg;
                        scan_ne_reg   <= step_ne_nx;
                        scan_slot_reg <= step_slot_nx;
                    end else begin
                        // Commit the final window position before any result
                        lio_reg     <= scan_last_reg;
                        ne_reg      <= scan_ne_reg;
                        ne_slot_reg <= scan_slot_reg;
                        rem_reg     <= cnt_reg;
                        last_reg    <= (cnt_reg == '0);
                        state_reg   <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (m_ready) begin
                        state_reg <= last_reg ? ST_IDLE : ST_FETCH;
                    end
                end

                ST_FETCH: begin
                    state_reg <= ST_LOAD;
                end

                ST_LOAD: begin
                    act_reg     <= rrw_pkg::ACT_DELIVER;
                    out_tag_reg <= rrw_pkg::TAG_IN_W'(rd_tag);
                    expl_reg    <= 1'b0;
                    last_reg    <= (rem_reg == SLOT_W'(1));
                    rem_reg     <= rem_reg - SLOT_W'(1);
                    em_ne_reg   <= step_ne_nx;
                    em_slot_reg <= step_slot_nx;
                    state_reg   <= ST_EMIT;
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_EMIT);
    assign m_action       = act_reg;
    assign m_out_tag      = out_tag_reg;
    assign m_ack_seq      = rrw_pkg::SEQ_IN_W'(lio_reg);
    assign m_ack_needed   = owed_reg;
    assign m_explicit_ack = expl_reg;
    assign m_last         = last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `RRW_NEVER(a_no_input_while_result, s_ready && m_valid, "input open with result pending")
    `RRW_ASSERT(a_more_blocks_input, m_valid && m_ready && !m_last |=> !s_ready, "input open mid-burst")
    `RRW_ASSERT(a_last_frees_input, m_valid && m_ready && m_last |=> s_ready, "input not reopened after last")
    `RRW_ASSERT(a_drain_no_explicit, state_reg == ST_LOAD |=> !m_explicit_ack, "explicit ack on drained result")
    `RRW_ASSERT(a_last_count_empty, m_valid && m_last |-> rem_reg == '0, "last result with drains left")

endmodule
